[design/ptt_pkg.sv]
package ptt_pkg;

	localparam int NUM_SLOTS_DEF = 16;

	// field widths
	localparam int TIME_W = 32;
	localparam int MASK_W = 16;
	localparam int IDX_OUT_W = 4;

	// stream widths, data padded to whole bytes
	localparam int IN_DATA_W = 104;
	localparam int IN_USER_W = 1;
	localparam int OUT_DATA_W = 72;

	// action codes
	localparam logic ACT_REGISTER = 1'b0;
	localparam logic ACT_SERVICE = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic load;   // capture input item
		logic claim;  // register a slot, clear walk accumulators
		logic step;   // process slot at walk index
		logic emit;   // load result into output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;  // output register can take a result
	} sts_t;

endpackage

[design/ptt_ctrl.sv]
module ptt_ctrl import ptt_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF,
	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  sts_t             sts,
	output cmd_t             cmd,
	output logic [IDX_W-1:0] idx
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CLAIM = 2'd1;
	localparam logic [1:0] ST_WALK  = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

	logic [1:0]       state_q;
	logic [IDX_W-1:0] idx_q;

	assign s_tready = (state_q == ST_IDLE);
	assign idx = idx_q;

	always_comb begin
		cmd = '0;
		cmd.load = s_tvalid & s_tready;
		cmd.claim = (state_q == ST_CLAIM);
		cmd.step = (state_q == ST_WALK);
		cmd.emit = (state_q == ST_FIN) & sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) state_q <= ST_CLAIM;
				end
				ST_CLAIM: begin
					idx_q <= '0;
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (idx_q == LAST_IDX) begin
						state_q <= ST_FIN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_FIN: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[design/ptt_dp.sv]
module ptt_dp import ptt_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF,
	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [IN_USER_W-1:0]  s_tuser,
	input  cmd_t                  cmd,
	input  logic [IDX_W-1:0]      idx,
	output sts_t                  sts,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata
);

	// captured item
	logic              act_q;
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] rep_q;
	logic              walarm_q;
	logic [MASK_W-1:0] amask_q;
	logic [MASK_W-1:0] kmask_q;

	// slot table
	logic [NUM_SLOTS-1:0] active_q;
	logic [NUM_SLOTS-1:0] alarm_en_q;
	logic [TIME_W-1:0]    period_q   [NUM_SLOTS];
	logic [TIME_W-1:0]    deadline_q [NUM_SLOTS];

	// result accumulators
	logic                 accepted_q;
	logic [IDX_OUT_W-1:0] index_q;
	logic [MASK_W-1:0]    fired_q;
	logic [MASK_W-1:0]    removed_q;
	logic                 any_q;
	logic [TIME_W-1:0]    best_q;

	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	// lowest free slot
	logic             free_found;
	logic [IDX_W-1:0] free_idx;
	logic [5:0]       free_ext;
	logic             claim_ok;

	// walk step
	logic [5:0]        idx_ext;
	logic              in_mask;
	logic              abit;
	logic              kbit;
	logic              cur_act;
	logic [TIME_W-1:0] cur_per;
	logic [TIME_W-1:0] diff;
	logic              fire;
	logic              stays;
	logic [TIME_W-1:0] rearm;

	always_comb begin
		free_found = 1'b0;
		free_idx = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_found = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
	end

	assign free_ext = 6'(free_idx);
	assign claim_ok = (act_q == ACT_REGISTER) && (rep_q != '0) && free_found;

	assign idx_ext = 6'(idx);
	assign in_mask = (idx_ext < 6'd16);
	assign abit = in_mask & amask_q[idx_ext[3:0]];
	assign kbit = in_mask & kmask_q[idx_ext[3:0]];
	assign cur_act = active_q[idx];
	assign cur_per = period_q[idx];
	assign diff = now_q - deadline_q[idx];
	// signed wrap-safe compare: deadline reached when now - deadline >= 0
	assign fire = (act_q == ACT_SERVICE) & cur_act & ((alarm_en_q[idx] & abit) | ~diff[TIME_W-1]);
	assign stays = cur_act & ~(fire & ~kbit);
	assign rearm = cur_per[TIME_W-1] ? now_q : (now_q + cur_per);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= s_tuser[0];
			now_q <= s_tdata[31:0];
			rep_q <= s_tdata[63:32];
			walarm_q <= s_tdata[64];
			amask_q <= s_tdata[80:65];
			kmask_q <= s_tdata[96:81];
		end
		if (cmd.claim) begin
			if (claim_ok) begin
				alarm_en_q[free_idx] <= walarm_q;
				period_q[free_idx] <= rep_q;
				deadline_q[free_idx] <= now_q + rep_q;
			end
			accepted_q <= (act_q == ACT_SERVICE) | claim_ok;
			index_q <= claim_ok ? free_ext[3:0] : '0;
			fired_q <= '0;
			removed_q <= '0;
			any_q <= 1'b0;
			best_q <= '0;
		end
		if (cmd.step) begin
			if (fire) begin
				if (in_mask) fired_q[idx_ext[3:0]] <= 1'b1;
				if (!kbit) begin
					if (in_mask) removed_q[idx_ext[3:0]] <= 1'b1;
				end else begin
					deadline_q[idx] <= rearm;
				end
			end
			if (stays) begin
				any_q <= 1'b1;
				if ((best_q == '0) || (cur_per < best_q)) best_q <= cur_per;
			end
		end
		if (cmd.emit) begin
			out_data_q <= {2'b00, best_q, any_q, removed_q, fired_q, index_q, accepted_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else if (cmd.claim && claim_ok) begin
			active_q[free_idx] <= 1'b1;
		end else if (cmd.step && fire && !kbit) begin
			active_q[idx] <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.out_free = ~out_valid_q | m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

endmodule

[design/periodic_timer_table.sv]
// Periodic timer table: up to NUM_SLOTS periodic slots on a wrapping
// 32-bit microsecond clock.
// Input stream (s_*): one item per command. s_tuser selects the action:
// register a slot (claims lowest free slot, deadline = now + period) or
// service (fire by alarm or deadline, free or re-arm fired slots).
// Output stream (m_*): exactly one result item per input item, in order.
// After an input is accepted the sequencer runs a claim state, walks
// every slot once, reading its period and deadline, and then loads the
// result into the output register once that register is free. A new
// item is not accepted until the previous one has been handed off.
// s_tready is high only while the sequencer is idle.
// Receiver stall: the result sits in the output register; the next item
// is still accepted and walked, and only waits at the end of its walk
// until the output register is free.
// Reset: arst_n clears all slots to inactive and empties the output
// register; period, deadline and alarm flags are written on claim.
module periodic_timer_table import ptt_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// now_us[31:0], period_us[63:32], want_alarm[64], alarm_mask[80:65],
	// keep_mask[96:81], zero pad[103:97]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// action[0]
	input  logic [IN_USER_W-1:0]  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// accepted[0], slot_index[4:1], fired_mask[20:5], removed_mask[36:21],
	// any_active[37], min_period[69:38], zero pad[71:70]
	output logic [OUT_DATA_W-1:0] m_tdata
);

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	cmd_t             cmd;
	sts_t             sts;
	logic [IDX_W-1:0] idx;

	// sequencer: idle -> claim -> walk over slots -> hand off result
	ptt_ctrl #(.NUM_SLOTS(NUM_SLOTS)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd),
		.idx      (idx)
	);

	// slot table, per-slot fire/re-arm logic, min-period scan, output reg
	ptt_dp #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cmd      (cmd),
		.idx      (idx),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// a result is never pushed over one still waiting
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result loaded while output register busy");

	// claim and walk come between accept and result: none follows directly
	a_no_fast_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !$rose(m_tvalid))
		else $error("result appeared before slot walk");

	// an empty table reports zero min period
	a_empty_min: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[37]) |-> (m_tdata[69:38] == '0))
		else $error("min period nonzero with no active slot");

	// only one command phase at a time
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.claim, cmd.step, cmd.emit}))
		else $error("overlapping sequencer commands");

endmodule
